// ===== src/sfr_pkg.sv =====
// Shared constants, register indexes and types of the stream find-and-replace unit.
package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int MAX_RESULTS     = 8;
    localparam int WIN_SLOTS       = MAX_PATTERN + 1;
    localparam int CNT_W           = $clog2(WIN_SLOTS + 1);
    localparam int LEN_W           = 4;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES = 2'd0,
        CFG_PATTERN_LEN   = 2'd1,
        CFG_REPL_BYTES    = 2'd2,
        CFG_REPL_LEN      = 2'd3
    } t_cfg_idx;

    typedef logic [MAX_PATTERN-1:0][7:0] t_win;
    typedef logic [MAX_RESULTS-1:0][7:0] t_res_bytes;

    // Results produced by one request, sent out one per cycle while the output is not stalled
    typedef struct packed {
        t_res_bytes       bytes;
        logic [CNT_W-1:0] num;
        logic             bval;
        logic             last;
    } t_burst;

endpackage

// ===== src/stream_find_and_replace_unit.sv =====
// A request is registered on acceptance; its results are then shown from the burst register.
// One request per cycle while each yields at most one result and the output is not stalled;
// a request with more results holds both registers until its last result is being taken.
// Reset (synchronous, active low) empties both registers, clears the pending window count
// and sets all configuration registers to zero.
// Top level: input register, step logic, and a result burst register shifted on each transfer.
module stream_find_and_replace_unit
    import sfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // [7:0] data_byte
    input  logic                 i_s_axis_tlast,   // end_of_string
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,   // [7:0] out_byte
    output logic                 o_m_axis_tuser,   // [0] byte_valid
    output logic                 o_m_axis_tlast,   // last
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    logic [CFG_W-1:0] r_pat_bytes;
    logic [LEN_W-1:0] r_pat_len;
    logic [CFG_W-1:0] r_rep_bytes;
    logic [LEN_W-1:0] r_rep_len;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eos;

    t_win             r_win;
    logic [CNT_W-1:0] r_cnt;
    t_burst           r_burst;

    t_win             n_win;
    logic [CNT_W-1:0] n_cnt;
    t_burst           n_burst;

    logic             pop;
    logic             load_ok;
    logic             consume;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= '0;
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PATTERN_BYTES: r_pat_bytes <= i_cfg_wdata;
                CFG_PATTERN_LEN:   r_pat_len   <= i_cfg_wdata[LEN_W-1:0];
                CFG_REPL_BYTES:    r_rep_bytes <= i_cfg_wdata;
                CFG_REPL_LEN:      r_rep_len   <= i_cfg_wdata[LEN_W-1:0];
                default:           r_pat_len   <= r_pat_len;
            endcase
        end
    end

    // Handshake control
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign load_ok         = (r_burst.num == '0) || (r_burst.num == CNT_W'(1) && i_m_axis_tready);
    assign consume         = r_in_valid && load_ok;
    assign o_s_axis_tready = !r_in_valid || load_ok;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eos  <= i_s_axis_tlast;
        end
    end

    sfr_step u_step (
        .i_win       (r_win),
        .i_cnt       (r_cnt),
        .i_byte      (r_in_byte),
        .i_eos       (r_in_eos),
        .i_pat_bytes (r_pat_bytes),
        .i_pat_len   (r_pat_len),
        .i_rep_bytes (r_rep_bytes),
        .i_rep_len   (r_rep_len),
        .o_win       (n_win),
        .o_cnt       (n_cnt),
        .o_burst     (n_burst)
    );

    // Pending window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (consume) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_win <= n_win;
        end
    end

    // Result burst register: load a new burst or shift out one result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst.num <= '0;
        end else if (consume) begin
            r_burst <= n_burst;
        end else if (pop) begin
            r_burst.num <= r_burst.num - CNT_W'(1);
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_burst.bytes[i] <= r_burst.bytes[i+1];
            end
            r_burst.bytes[MAX_RESULTS-1] <= 8'd0;
        end
    end

    assign o_m_axis_tvalid = r_burst.num != '0;
    assign o_m_axis_tdata  = r_burst.bytes[0];
    assign o_m_axis_tuser  = r_burst.bval;
    assign o_m_axis_tlast  = r_burst.last && (r_burst.num == CNT_W'(1));

endmodule

// ===== src/sfr_step.sv =====
// Combinational step: appends one byte to the window, compares, builds the result burst.
module sfr_step
    import sfr_pkg::*;
(
    input  t_win             i_win,
    input  logic [CNT_W-1:0] i_cnt,
    input  logic [7:0]       i_byte,
    input  logic             i_eos,
    input  logic [CFG_W-1:0] i_pat_bytes,
    input  logic [LEN_W-1:0] i_pat_len,
    input  logic [CFG_W-1:0] i_rep_bytes,
    input  logic [LEN_W-1:0] i_rep_len,
    output t_win             o_win,
    output logic [CNT_W-1:0] o_cnt,
    output t_burst           o_burst
);

    logic [WIN_SLOTS-1:0][7:0] w9;
    logic [CNT_W-1:0]          cnt1;
    logic [LEN_W-1:0]          plen;
    logic [LEN_W-1:0]          rlen;
    logic                      same;
    logic                      over;
    logic                      full;

    // Clamp the configured lengths
    assign plen = (i_pat_len > LEN_W'(MAX_PATTERN))     ? LEN_W'(MAX_PATTERN)     : i_pat_len;
    assign rlen = (i_rep_len > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : i_rep_len;
    assign cnt1 = i_cnt + CNT_W'(1);

    // Window with the new byte appended
    always_comb begin
        w9 = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CNT_W'(i) < i_cnt) begin
                w9[i] = i_win[i];
            end
        end
        for (int i = 0; i < WIN_SLOTS; i++) begin
            if (CNT_W'(i) == i_cnt) begin
                w9[i] = i_byte;
            end
        end
    end

    // Pattern compare over the bytes in use
    always_comb begin
        same = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (LEN_W'(i) < plen && w9[i] != i_pat_bytes[8*i +: 8]) begin
                same = 1'b0;
            end
        end
    end

    assign over = CNT_W'(plen) < cnt1;
    assign full = CNT_W'(plen) == cnt1;

    // Next window and burst
    always_comb begin
        o_win       = '0;
        o_cnt       = '0;
        o_burst     = '0;
        o_burst.bval = 1'b1;
        o_burst.last = i_eos;
        priority if (full && same) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                o_burst.bytes[i] = i_rep_bytes[8*i +: 8];
            end
            o_burst.num = CNT_W'(rlen);
        end else if (over || full) begin
            // emit oldest, shift; on end of string the rest follows it
            for (int i = 0; i < MAX_PATTERN; i++) begin
                o_win[i] = w9[i+1];
            end
            for (int i = 0; i < MAX_RESULTS; i++) begin
                o_burst.bytes[i] = w9[i];
            end
            o_cnt = i_cnt;
            if (i_eos) begin
                o_burst.num = (i_cnt >= CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : cnt1;
            end else begin
                o_burst.num = CNT_W'(1);
            end
        end else begin
            // still filling
            for (int i = 0; i < MAX_PATTERN; i++) begin
                o_win[i] = w9[i];
            end
            for (int i = 0; i < MAX_RESULTS; i++) begin
                o_burst.bytes[i] = w9[i];
            end
            o_cnt       = cnt1;
            o_burst.num = i_eos ? cnt1 : '0;
        end

        // End of string clears the window; an empty end gets a bare marker
        if (i_eos) begin
            o_cnt = '0;
            if (o_burst.num == '0) begin
                o_burst.bytes = '0;
                o_burst.num   = CNT_W'(1);
                o_burst.bval  = 1'b0;
            end
        end
    end

endmodule

// ===== src/sfr_checker.sv =====
// Port-level checks of the stream find-and-replace unit, bound to the top level.
module sfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A bare marker is always the last result and carries a zero byte
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tlast && o_m_axis_tdata == 8'd0))
        else $error("bare marker without last or with nonzero byte");

    // The input side only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no result pending");

    // A stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind stream_find_and_replace_unit sfr_checker u_sfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
